[design/tpsg_pkg.sv]
package tpsg_pkg;

    // fixed field widths
    localparam int AMP_BITS   = 16;
    localparam int WORD_BITS  = 32;
    localparam int OUT_BITS   = 16;
    localparam int LANES      = 3;

    // one third of a full cycle, 2^32/3 rounded down
    localparam logic [WORD_BITS-1:0] THIRD_CYCLE = 32'h5555_5555;

    // pi/2 in q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // output clamp limits
    localparam int OUT_MAX_VAL = 32767;
    localparam int OUT_MIN_VAL = -32768;

    // lane order on the result side
    typedef enum logic [1:0] {
        LANE_A = 2'd0,
        LANE_B = 2'd1,
        LANE_C = 2'd2
    } lane_t;

endpackage

[design/tpsg_sine_rom.sv]
module tpsg_sine_rom
    import tpsg_pkg::*;
#(
    parameter int TABLE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [TABLE_ADDR_BITS:0]   rd_addr,
    output logic [SAMPLE_BITS-2:0]     rd_data
);

    localparam int ROM_SIZE = (1 << TABLE_ADDR_BITS) + 1;

    typedef logic [SAMPLE_BITS-2:0] rom_t [ROM_SIZE];

    // quarter-wave table, q30 taylor series up to the x^15 term
    function automatic rom_t build_rom();
        rom_t        tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] prod;
        logic [63:0] v;
        longint      sum;
        longint      top;
        top = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
        for (int k = 0; k < ROM_SIZE; k++) begin
            x = (HALF_PI_Q30 * 64'(k) + (64'd1 << (TABLE_ADDR_BITS - 1))) >> TABLE_ADDR_BITS;
            x2 = (x * x) >> 30;
            term = x;
            sum = longint'(x);
            for (int i = 1; i <= 7; i++) begin
                prod = (term * x2) >> 30;
                case (i)
                    1:       term = prod / 64'd6;
                    2:       term = prod / 64'd20;
                    3:       term = prod / 64'd42;
                    4:       term = prod / 64'd72;
                    5:       term = prod / 64'd110;
                    6:       term = prod / 64'd156;
                    default: term = prod / 64'd210;
                endcase
                if ((i % 2) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            v = ((64'(sum) << (SAMPLE_BITS - 1)) + (64'd1 << 29)) >> 30;
            if (longint'(v) > top) begin
                v = 64'(top);
            end
            tab[k] = v[SAMPLE_BITS-2:0];
        end
        return tab;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [SAMPLE_BITS-2:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            rd_data_reg <= SINE_ROM[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/three_phase_sine_gen.sv]
// channel   ports                                              dir   handshake
// input     s_amplitude, s_freq_word, s_tick_count             in    s_valid / s_ready
// result    m_phase_a_out, m_phase_b_out, m_phase_c_out        out   m_valid / m_ready
//
// five register stages: phase multiply, lane address fold, sine rom read,
// amplitude multiply, round and saturate
// one item per cycle while the output slot is free or m_ready is high, set by the single global stage enable
// aresetn (synchronous, active low) clears only the stage valid bits
// a stall on m_ready freezes every stage at once, so nothing is lost or repeated
// the sine table is a constant rom, so no fill pass follows reset
module three_phase_sine_gen
    import tpsg_pkg::*;
#(
    parameter int TABLE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [AMP_BITS-1:0]  s_amplitude,
    input  logic [WORD_BITS-1:0]        s_freq_word,
    input  logic [WORD_BITS-1:0]        s_tick_count,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [OUT_BITS-1:0]  m_phase_a_out,
    output logic signed [OUT_BITS-1:0]  m_phase_b_out,
    output logic signed [OUT_BITS-1:0]  m_phase_c_out
);

    localparam int STAGES = 5;
    localparam int ADDR_W = TABLE_ADDR_BITS + 1;
    localparam int PROD_W = AMP_BITS + SAMPLE_BITS;
    localparam int RND_W  = PROD_W - (SAMPLE_BITS - 1);

    // half an lsb of the result, added before the floor shift
    localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(1) << (SAMPLE_BITS - 2);
    localparam logic signed [RND_W-1:0]  SAT_MAX  = RND_W'(OUT_MAX_VAL);
    localparam logic signed [RND_W-1:0]  SAT_MIN  = RND_W'(OUT_MIN_VAL);
    localparam logic [ADDR_W-1:0]        ADDR_TOP = ADDR_W'(1) << TABLE_ADDR_BITS;

    // one valid bit per stage; the last one is the output register
    logic [STAGES-1:0] vld_reg;
    logic              en;

    // whole pipeline moves when the output slot is free or being drained
    assign en      = m_ready | ~vld_reg[STAGES-1];
    assign s_ready = en;
    assign m_valid = vld_reg[STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[STAGES-2:0], s_valid};
        end
    end

    // stage 1: phase = freq_word * tick_count mod 2^32
    logic [WORD_BITS-1:0]        phase_reg;
    logic [WORD_BITS-1:0]        phase_next;
    logic signed [AMP_BITS-1:0]  amp1_reg;
    logic signed [AMP_BITS-1:0]  amp2_reg;
    logic signed [AMP_BITS-1:0]  amp3_reg;

    assign phase_next = WORD_BITS'(s_freq_word * s_tick_count);

    always_ff @(posedge aclk) begin
        if (en) begin
            phase_reg <= phase_next;
            amp1_reg  <= s_amplitude;
            amp2_reg  <= amp1_reg;
            amp3_reg  <= amp2_reg;
        end
    end

    // per-lane registers
    logic [ADDR_W-1:0]             addr_reg [LANES];
    logic [ADDR_W-1:0]             addr_next [LANES];
    logic                          neg2_reg [LANES];
    logic                          neg3_reg [LANES];
    logic [SAMPLE_BITS-2:0]        rom_data [LANES];
    logic signed [PROD_W-1:0]      prod_reg [LANES];
    logic signed [PROD_W-1:0]      prod_next [LANES];
    logic signed [OUT_BITS-1:0]    out_reg [LANES];
    logic signed [OUT_BITS-1:0]    out_next [LANES];

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        logic [WORD_BITS-1:0]          lane_phase;
        logic [TABLE_ADDR_BITS-1:0]    idx;
        logic signed [SAMPLE_BITS-1:0] smp;
        logic signed [PROD_W-1:0]      biased;
        logic signed [RND_W-1:0]       rnd;

        // stage 2: lane phase offset, quadrant fold to a rom address
        always_comb begin
            case (lane_t'(g))
                LANE_B:  lane_phase = phase_reg - THIRD_CYCLE;
                LANE_C:  lane_phase = phase_reg + THIRD_CYCLE;
                default: lane_phase = phase_reg;
            endcase
        end

        assign idx = lane_phase[WORD_BITS-3 -: TABLE_ADDR_BITS];
        // odd quadrants read the table backwards
        assign addr_next[g] = lane_phase[WORD_BITS-2] ? (ADDR_TOP - ADDR_W'(idx))
                                                      : ADDR_W'(idx);

        always_ff @(posedge aclk) begin
            if (en) begin
                addr_reg[g] <= addr_next[g];
                neg2_reg[g] <= lane_phase[WORD_BITS-1];
                neg3_reg[g] <= neg2_reg[g];
            end
        end

        // stage 3: registered rom read
        tpsg_sine_rom #(
            .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
            .SAMPLE_BITS     (SAMPLE_BITS)
        ) u_rom (
            .aclk    (aclk),
            .en      (en),
            .rd_addr (addr_reg[g]),
            .rd_data (rom_data[g])
        );

        // stage 4: signed sample times amplitude
        assign smp = neg3_reg[g] ? -$signed({1'b0, rom_data[g]})
                                 :  $signed({1'b0, rom_data[g]});
        assign prod_next[g] = amp3_reg * smp;

        // stage 5: round half up, then clamp to the 16-bit range
        assign biased = prod_reg[g] + HALF_LSB;
        assign rnd    = biased[PROD_W-1:SAMPLE_BITS-1];

        always_comb begin
            if (rnd > SAT_MAX) begin
                out_next[g] = OUT_BITS'(SAT_MAX);
            end else if (rnd < SAT_MIN) begin
                out_next[g] = OUT_BITS'(SAT_MIN);
            end else begin
                out_next[g] = rnd[OUT_BITS-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                prod_reg[g] <= prod_next[g];
                out_reg[g]  <= out_next[g];
            end
        end
    end

    assign m_phase_a_out = out_reg[LANE_A];
    assign m_phase_b_out = out_reg[LANE_B];
    assign m_phase_c_out = out_reg[LANE_C];

    // a stall freezes every valid bit
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    // an accepted item shows up in the first stage
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> vld_reg[0])
        else $error("accepted item missing from first stage");

    // folded address never goes past the table end
    a_addr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[1] |-> (addr_reg[LANE_A] <= ADDR_TOP && addr_reg[LANE_B] <= ADDR_TOP
                        && addr_reg[LANE_C] <= ADDR_TOP))
        else $error("rom address beyond quarter-wave table");

    // zero amplitude gives zero products on every lane
    a_zero_amp: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && vld_reg[2] && amp3_reg == '0) |=>
            (prod_reg[LANE_A] == '0 && prod_reg[LANE_B] == '0 && prod_reg[LANE_C] == '0))
        else $error("nonzero product for zero amplitude");

endmodule
